// ===== rtl/fdc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the fan duty controller.
package fdc_pkg;

    localparam int TEMP_W  = 8;
    localparam int RAW_W   = 8;
    localparam int COUNT_W = 16;
    localparam int PCT_W   = 7;
    localparam int SPEED_W = 22;
    localparam int BYTE_W  = 8;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 64;
    localparam int STEP_W  = 5;

    localparam logic [SPEED_W-1:0] SPEED_NUM = 22'd2156220;
    localparam logic [STEP_W-1:0]  LAST_STEP = STEP_W'(SPEED_W - 1);
    localparam logic [PCT_W-1:0]   DUTY_MIN  = 7'd40;
    localparam logic [PCT_W-1:0]   DUTY_MAX  = 7'd100;
    localparam logic [PCT_W-1:0]   DUTY_NONE = 7'd0;
    localparam logic [27:0]        RECIP_100 = 28'd5243;

    localparam logic [TEMP_W-1:0] UP_TEMP [7] = '{8'd80, 8'd70, 8'd60, 8'd50, 8'd40, 8'd30, 8'd20};
    localparam logic [PCT_W-1:0]  UP_DUTY [7] = '{7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40};
    localparam logic [TEMP_W-1:0] DN_TEMP [6] = '{8'd15, 8'd25, 8'd35, 8'd45, 8'd55, 8'd65};
    localparam logic [PCT_W-1:0]  DN_DUTY [6] = '{7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90};

    typedef struct packed {
        logic load;
        logic pct_en;
        logic decide_en;
        logic conv_en;
        logic out_load;
    } fdc_cmd_t;

    typedef struct packed {
        logic div_done;
    } fdc_sts_t;

    // Duty byte to percent: raw*100/255 through the reciprocal identity for 255.
    function automatic logic [PCT_W-1:0] pct_of(input logic [RAW_W-1:0] raw);
        logic [14:0] x;
        logic [14:0] sum;
        x   = {7'd0, raw} * 15'd100;
        sum = x + (x >> 8) + 15'd1;
        return sum[14:8];
    endfunction

    // Percent to duty byte: duty*255/100 through a multiply by the reciprocal of 100.
    function automatic logic [BYTE_W-1:0] duty_to_byte(input logic [PCT_W-1:0] duty);
        logic [14:0] x;
        logic [27:0] prod;
        x    = {8'd0, duty} * 15'd255;
        prod = {13'd0, x} * RECIP_100;
        return prod[26:19];
    endfunction

    // Stepped curve: the first matching rising step wins, then the first falling step.
    function automatic logic [PCT_W-1:0] curve_target(input logic [TEMP_W-1:0] temp,
                                                      input logic [PCT_W-1:0] pct);
        logic [PCT_W-1:0] result;
        result = DUTY_NONE;
        for (int i = 5; i >= 0; i--) begin
            if (temp <= DN_TEMP[i] && pct > DN_DUTY[i]) begin
                result = DN_DUTY[i];
            end
        end
        for (int i = 6; i >= 0; i--) begin
            if (temp >= UP_TEMP[i] && pct < UP_DUTY[i]) begin
                result = UP_DUTY[i];
            end
        end
        return result;
    endfunction

endpackage

// ===== rtl/fan_duty_controller.sv =====
// Top level of the fan duty controller: stream ports, configuration port and submodules.
// Each accepted snapshot yields one result beat. A new snapshot is accepted only after the
// previous one has been loaded into the output register. The two fan speeds come from a
// pair of restoring dividers that produce one quotient bit per cycle. The duty percent,
// curve decision and duty byte are worked out in the PCT, DECIDE and CONV states alongside
// them, and the WAIT state loads the output register once both dividers are done and the
// output register is free. A finished result waits in the output register while the next
// snapshot is already being worked on. The manual duty register may be written only while
// no snapshot is in progress; any write also clears the last automatic duty.
module fan_duty_controller (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [fdc_pkg::PCT_W-1:0]     cfg_wdata,    // manual_duty
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // core_temp[7:0], gfx_temp[15:8], duty_raw[23:16], fan1_count[39:24], fan2_count[55:40]
    input  logic [fdc_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // duty_percent[6:0], fan1_speed[28:7], fan2_speed[50:29], write_value[58:51], zero fill
    output logic [fdc_pkg::M_DATA_W-1:0]  m_tdata,
    // write_enable[0]
    output logic                          m_tuser
);
    import fdc_pkg::*;

    fdc_cmd_t cmd;
    fdc_sts_t sts;

    fdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fdc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/fdc_divider.sv =====
// Restoring divider that turns a tachometer count into a speed, one quotient bit per cycle.
module fdc_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [fdc_pkg::COUNT_W-1:0]  divisor,
    output logic [fdc_pkg::SPEED_W-1:0]  quotient,
    output logic                         done
);
    import fdc_pkg::*;

    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [COUNT_W-1:0]  div_reg;
    logic [COUNT_W-1:0]  rem_reg;
    logic [SPEED_W-1:0]  quo_reg;
    logic                zero_reg;
    logic [COUNT_W:0]    rem_shift;
    logic [COUNT_W:0]    rem_diff;
    logic                fits;

    assign rem_shift = {rem_reg, SPEED_NUM[step_reg]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign fits      = rem_shift >= {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = LAST_STEP;
        end else if (busy_reg) begin
            if (step_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg  <= divisor;
            zero_reg <= (divisor == '0);
            rem_reg  <= '0;
            quo_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
            quo_reg <= {quo_reg[SPEED_W-2:0], fits};
        end
    end

    assign quotient = zero_reg ? '0 : quo_reg;
    assign done     = !busy_reg;

endmodule

// ===== rtl/fdc_datapath.sv =====
// Datapath: input capture, percent conversion, duty decision, speed dividers and result register.
module fdc_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [fdc_pkg::PCT_W-1:0]     cfg_wdata,
    input  logic [fdc_pkg::S_DATA_W-1:0]  s_tdata,
    input  fdc_pkg::fdc_cmd_t             cmd,
    output fdc_pkg::fdc_sts_t             sts,
    output logic [fdc_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser
);
    import fdc_pkg::*;

    logic [TEMP_W-1:0]  cpu_reg;
    logic [TEMP_W-1:0]  gpu_reg;
    logic [RAW_W-1:0]   raw_reg;
    logic [PCT_W-1:0]   pct_reg;
    logic               wen_reg;
    logic [PCT_W-1:0]   duty_sel_reg;
    logic [BYTE_W-1:0]  wval_reg;
    logic [PCT_W-1:0]   manual_reg, manual_next;
    logic [PCT_W-1:0]   last_auto_reg, last_auto_next;
    logic [PCT_W-1:0]   last_manual_reg, last_manual_next;
    logic               wen_next;
    logic [PCT_W-1:0]   duty_sel_next;
    logic [TEMP_W-1:0]  hot_temp;
    logic [PCT_W-1:0]   target;
    logic [SPEED_W-1:0] speed1, speed2;
    logic               done1, done2;
    logic [PCT_W-1:0]   out_pct_reg;
    logic [SPEED_W-1:0] out_speed1_reg, out_speed2_reg;
    logic [BYTE_W-1:0]  out_wval_reg;
    logic               out_wen_reg;

    fdc_divider u_div1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.load),
        .divisor  (s_tdata[39:24]),
        .quotient (speed1),
        .done     (done1)
    );

    fdc_divider u_div2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.load),
        .divisor  (s_tdata[55:40]),
        .quotient (speed2),
        .done     (done2)
    );

    assign sts.div_done = done1 && done2;

    assign hot_temp = (cpu_reg > gpu_reg) ? cpu_reg : gpu_reg;
    assign target   = curve_target(hot_temp, pct_reg);

    always_comb begin
        manual_next      = manual_reg;
        last_auto_next   = last_auto_reg;
        last_manual_next = last_manual_reg;
        wen_next         = 1'b0;
        duty_sel_next    = DUTY_NONE;
        if (cfg_we) begin
            manual_next    = cfg_wdata;
            last_auto_next = DUTY_NONE;
        end else if (cmd.decide_en) begin
            if (manual_reg != DUTY_NONE) begin
                duty_sel_next = manual_reg;
                if (manual_reg != last_manual_reg) begin
                    wen_next         = (manual_reg >= DUTY_MIN) && (manual_reg <= DUTY_MAX);
                    last_manual_next = manual_reg;
                end
            end else begin
                duty_sel_next = target;
                if (target != DUTY_NONE && target != last_auto_reg) begin
                    wen_next       = 1'b1;
                    last_auto_next = target;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            manual_reg      <= '0;
            last_auto_reg   <= '0;
            last_manual_reg <= '0;
        end else begin
            manual_reg      <= manual_next;
            last_auto_reg   <= last_auto_next;
            last_manual_reg <= last_manual_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cpu_reg <= s_tdata[7:0];
            gpu_reg <= s_tdata[15:8];
            raw_reg <= s_tdata[23:16];
        end
        if (cmd.pct_en) begin
            pct_reg <= pct_of(raw_reg);
        end
        if (cmd.decide_en) begin
            wen_reg      <= wen_next;
            duty_sel_reg <= duty_sel_next;
        end
        if (cmd.conv_en) begin
            wval_reg <= wen_reg ? duty_to_byte(duty_sel_reg) : '0;
        end
        if (cmd.out_load) begin
            out_pct_reg    <= pct_reg;
            out_speed1_reg <= speed1;
            out_speed2_reg <= speed2;
            out_wval_reg   <= wval_reg;
            out_wen_reg    <= wen_reg;
        end
    end

    assign m_tdata = {5'd0, out_wval_reg, out_speed2_reg, out_speed1_reg, out_pct_reg};
    assign m_tuser = out_wen_reg;

endmodule

// ===== rtl/fdc_ctrl.sv =====
// Controller state machine that sequences one snapshot and owns both handshakes.
module fdc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  fdc_pkg::fdc_sts_t  sts,
    output fdc_pkg::fdc_cmd_t  cmd
);
    import fdc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PCT    = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_CONV   = 5'b01000,
        ST_WAIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PCT;
                end
            end
            ST_PCT: begin
                cmd.pct_en = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide_en = 1'b1;
                state_next    = ST_CONV;
            end
            ST_CONV: begin
                cmd.conv_en = 1'b1;
                state_next  = ST_WAIT;
            end
            ST_WAIT: begin
                if (sts.div_done && out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_load_needs_quotients: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.div_done)
        else $error("Result loaded before both speed divisions finished.");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("Result register overwritten while a beat is still waiting.");

    a_load_shows_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("Loaded result not presented on the output.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Second snapshot accepted while one is in progress.");

endmodule

// ===== test/tb_fan_duty_controller.sv =====
// Self-checking testbench for the fan duty controller: snapshot stream in, result stream out.
`timescale 1ns / 100ps

module tb_fan_duty_controller;

    import fdc_pkg::*;

    localparam int unsigned SPEED_DIVIDEND = 2156220;
    localparam int unsigned DUTY_FLOOR     = 40;
    localparam int unsigned DUTY_CEIL      = 100;
    localparam int unsigned AUTO_MODE      = 0;
    localparam int          QUIET_LIMIT    = 5000;
    localparam int          RANDOM_TARGET  = 1350;

    typedef struct packed {
        logic [COUNT_W-1:0] fan2_count;
        logic [COUNT_W-1:0] fan1_count;
        logic [RAW_W-1:0]   duty_raw;
        logic [TEMP_W-1:0]  gfx_temp;
        logic [TEMP_W-1:0]  core_temp;
    } snapshot_t;

    typedef struct packed {
        logic [M_DATA_W-PCT_W-2*SPEED_W-BYTE_W-1:0] fill;
        logic [BYTE_W-1:0]  write_value;
        logic [SPEED_W-1:0] fan2_speed;
        logic [SPEED_W-1:0] fan1_speed;
        logic [PCT_W-1:0]   duty_percent;
    } fan_beat_t;

    typedef struct packed {
        fan_beat_t beat;
        logic      write_enable;
    } fan_report_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic [PCT_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    snapshot_t   pending_snapshots[$];
    fan_report_t expected_reports[$];
    fan_report_t oldest_report;
    fan_beat_t   seen_beat;

    int unsigned manual_setting;
    int unsigned manual_taken;
    int unsigned auto_written;

    int burst_left;
    int gap_left;
    int ready_hold;
    int quiet_cycles = 0;
    int mismatch_count = 0;
    int cpu_walk = 40;
    int gpu_walk = 40;

    fan_duty_controller DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned curve_step(input int unsigned temp, input int unsigned pct);
        for (int duty = 100; duty >= 40; duty -= 10) begin
            if (temp + 20 >= duty && pct < duty) begin
                return duty;
            end
        end
        for (int duty = 40; duty <= 90; duty += 10) begin
            if (temp + 25 <= duty && pct > duty) begin
                return duty;
            end
        end
        return 0;
    endfunction

    function automatic fan_report_t fan_report_for(input snapshot_t snap);
        fan_report_t rep;
        int unsigned pct;
        int unsigned hotter;
        int unsigned target;
        rep = '0;
        pct = (int'(snap.duty_raw) * 100) / 255;
        rep.beat.duty_percent = PCT_W'(pct);
        rep.beat.fan1_speed = (snap.fan1_count == 0) ? '0
                                                     : SPEED_W'(SPEED_DIVIDEND / snap.fan1_count);
        rep.beat.fan2_speed = (snap.fan2_count == 0) ? '0
                                                     : SPEED_W'(SPEED_DIVIDEND / snap.fan2_count);
        if (manual_setting != AUTO_MODE) begin
            if (manual_setting != manual_taken) begin
                if (manual_setting >= DUTY_FLOOR && manual_setting <= DUTY_CEIL) begin
                    rep.write_enable = 1'b1;
                    rep.beat.write_value = BYTE_W'((manual_setting * 255) / 100);
                end
                manual_taken = manual_setting;
            end
        end else begin
            hotter = (snap.core_temp > snap.gfx_temp) ? snap.core_temp : snap.gfx_temp;
            target = curve_step(hotter, pct);
            if (target != 0 && target != auto_written) begin
                rep.write_enable = 1'b1;
                rep.beat.write_value = BYTE_W'((target * 255) / 100);
                auto_written = target;
            end
        end
        return rep;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            manual_setting = 0;
            manual_taken = 0;
            auto_written = 0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (cfg_we) begin
                manual_setting = cfg_wdata;
                auto_written = 0;
            end
            if (s_tvalid && s_tready) begin
                expected_reports.push_back(fan_report_for(pending_snapshots.pop_front()));
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 7);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_snapshots.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_snapshots[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_hold = 0;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    m_tready <= 1'b1;
                    ready_hold = $urandom_range(20, 200);
                end
                1: begin
                    m_tready <= 1'b0;
                    ready_hold = $urandom_range(1, 60);
                end
                default: begin
                    m_tready <= ($urandom_range(0, 1) != 0);
                    ready_hold = $urandom_range(0, 4);
                end
            endcase
        end
    end

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)) ? 0
                                                                              : quiet_cycles + 1;
            if (m_tvalid && m_tready) begin
                seen_beat = m_tdata;
                if (expected_reports.size() == 0) begin
                    $display("%0t: result beat with nothing pending, expected none, got %h",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    oldest_report = expected_reports.pop_front();
                    check_field("duty_percent", oldest_report.beat.duty_percent,
                                seen_beat.duty_percent);
                    check_field("fan1_speed", oldest_report.beat.fan1_speed,
                                seen_beat.fan1_speed);
                    check_field("fan2_speed", oldest_report.beat.fan2_speed,
                                seen_beat.fan2_speed);
                    check_field("write_value", oldest_report.beat.write_value,
                                seen_beat.write_value);
                    check_field("zero fill", oldest_report.beat.fill, seen_beat.fill);
                    check_field("write_enable", oldest_report.write_enable, m_tuser);
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("Test completed with failures");
        $finish;
    end

    task automatic queue_snapshot(input int cpu, input int gpu, input int raw,
                                  input int c1, input int c2);
        snapshot_t snap;
        snap.core_temp = TEMP_W'(cpu);
        snap.gfx_temp = TEMP_W'(gpu);
        snap.duty_raw = RAW_W'(raw);
        snap.fan1_count = COUNT_W'(c1);
        snap.fan2_count = COUNT_W'(c2);
        pending_snapshots.push_back(snap);
    endtask

    task automatic drain();
        while (pending_snapshots.size() != 0 || expected_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_manual_duty(input int value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= PCT_W'(value);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic int walk_temp(input int t);
        t = t + int'($urandom_range(0, 10)) - 5;
        if (t < 0) begin
            t = 0;
        end else if (t > 120) begin
            t = 120;
        end
        return t;
    endfunction

    function automatic int random_count();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(0, 1) ? 65535 : $urandom_range(1, 16);
            2, 3, 4, 5: return $urandom_range(500, 6000);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic queue_random_snapshot();
        int cpu;
        int gpu;
        int raw;
        cpu_walk = walk_temp(cpu_walk);
        gpu_walk = walk_temp(gpu_walk);
        cpu = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : cpu_walk;
        gpu = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : gpu_walk;
        if ($urandom_range(0, 9) < 7) begin
            // A fan normally reports close to one of the curve's duty steps.
            raw = ((40 + 10 * $urandom_range(0, 6)) * 255) / 100 + int'($urandom_range(0, 2)) - 1;
            raw = (raw > 255) ? 255 : raw;
        end else begin
            raw = $urandom_range(0, 255);
        end
        queue_snapshot(cpu, gpu, raw, random_count(), random_count());
    endtask

    initial begin
        int random_items;
        int setting;
        int phase_len;
        random_items = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        queue_snapshot(0, 0, 0, 0, 0);
        queue_snapshot(255, 0, 0, 1, 65535);
        queue_snapshot(255, 0, 0, 2, 1000);
        queue_snapshot(0, 255, 255, 65535, 1);
        queue_snapshot(10, 5, 255, 0, 0);
        queue_snapshot(0, 85, 102, 1078, 0);
        queue_snapshot(62, 40, 204, 3000, 3001);
        queue_snapshot(60, 0, 0, 43690, 21845);
        queue_snapshot(0, 59, 153, 255, 256);
        queue_snapshot(65, 65, 255, 1, 1);
        queue_snapshot(20, 0, 101, 65534, 2);
        queue_snapshot(15, 15, 3, 0, 65535);
        queue_snapshot(14, 0, 255, 1500, 1500);

        write_manual_duty(DUTY_CEIL);
        queue_snapshot(90, 90, 128, 1200, 1300);
        queue_snapshot(90, 90, 255, 1200, 1300);
        write_manual_duty(127);
        queue_snapshot(30, 30, 100, 900, 900);
        write_manual_duty(1);
        queue_snapshot(30, 30, 100, 900, 900);
        write_manual_duty(39);
        write_manual_duty(DUTY_FLOOR);
        queue_snapshot(30, 30, 100, 900, 900);
        write_manual_duty(DUTY_FLOOR);
        queue_snapshot(30, 30, 100, 900, 900);
        write_manual_duty(AUTO_MODE);
        queue_snapshot(90, 10, 0, 2000, 2000);
        write_manual_duty(DUTY_FLOOR);
        queue_snapshot(90, 10, 0, 2000, 2000);
        write_manual_duty(101);
        queue_snapshot(50, 50, 50, 2000, 2000);

        while (random_items < RANDOM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: setting = AUTO_MODE;
                5: setting = $urandom_range(1, 39);
                6: setting = $urandom_range(101, 127);
                7: setting = $urandom_range(0, 1) ? DUTY_FLOOR : DUTY_CEIL;
                default: setting = $urandom_range(DUTY_FLOOR, DUTY_CEIL);
            endcase
            phase_len = (setting == AUTO_MODE) ? $urandom_range(20, 120) : $urandom_range(3, 30);
            write_manual_duty(setting);
            repeat (phase_len) begin
                queue_random_snapshot();
            end
            random_items += phase_len;
        end

        drain();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
